FILE: rtl/icnt_pkg.sv
`timescale 1ns / 1ps

package icnt_pkg;

   localparam int RANK_W  = 11;
   localparam int COUNT_W = 30;
   localparam int TAG_W   = 8;

   localparam logic [COUNT_W-1:0] COUNT_MODULUS = COUNT_W'(1000000007);

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TAG_W-1:0]   tag_type;

endpackage

FILE: rtl/icnt_mod_adder.sv
`timescale 1ns / 1ps

module icnt_mod_adder
   import icnt_pkg::*;
(
   input  count_type add_a,
   input  count_type add_b,
   output count_type add_sum
);

   logic [COUNT_W:0] raw_sum;
   logic [COUNT_W:0] reduced;

   assign raw_sum = {1'b0, add_a} + {1'b0, add_b};
   assign reduced = raw_sum - {1'b0, COUNT_MODULUS};

   always_comb begin
      if (raw_sum >= {1'b0, COUNT_MODULUS}) begin
         add_sum = reduced[COUNT_W-1:0];
      end else begin
         add_sum = raw_sum[COUNT_W-1:0];
      end
   end

endmodule

FILE: rtl/increasing_subsequence_counter.sv
`timescale 1ns / 1ps
// An item passes from an input transfer through the query, finish, update and total states
// to the done state, which raises rsp_tvalid; rank zero goes straight to the done state.
// A new item is taken only in the idle state, once the last one is through; the
// single tree memory and one modular adder set this, and a held result stalls the input.
// Reset is synchronous; after reset a clearing pass over all VALUE_MAX tree entries runs
// before the first transfer, and every 255th restart repeats that pass.
module increasing_subsequence_counter
   import icnt_pkg::*;
#(
   parameter int VALUE_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits from the lowest up: value_rank [10:0], zero fill [15:11].
   input  logic [15:0] req_tdata,
   // Bits from the lowest up: restart [0].
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits from the lowest up: ending_here [29:0], running_total [59:30], zero fill [63:60].
   output logic [63:0] rsp_tdata
);

   localparam int AW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
   localparam int PW = $clog2(VALUE_MAX + 1) + 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SWEEP  = 3'd1;
   localparam logic [2:0] S_QUERY  = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_TOTAL  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [PW-1:0]     rank_ff, rank_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              pend_ff, pend_in;
   logic              item_ff, item_in;
   logic              zero_ff, zero_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   tag_type           epoch_ff, epoch_in;
   count_type         acc_ff, acc_in;
   count_type         here_ff, here_in;
   count_type         total_ff, total_in;
   logic              out_valid_ff, out_valid_in;
   count_type         out_here_ff, out_here_in;
   count_type         out_total_ff, out_total_in;

   logic [TAG_W+COUNT_W-1:0] tree_mem [VALUE_MAX];
   logic [TAG_W+COUNT_W-1:0] rd_data_ff;
   logic [TAG_W+COUNT_W-1:0] wr_data;
   logic                     mem_we;
   logic [AW-1:0]            mem_wa;
   logic [AW-1:0]            rd_addr;

   count_type     entry_val;
   count_type     add_a, add_b, add_sum;
   logic [PW-1:0] pos_dec, low_bit, rank_sat;
   logic          pos_in_range, saturate, accept;

   icnt_mod_adder u_adder (
      .add_a   (add_a),
      .add_b   (add_b),
      .add_sum (add_sum)
   );

   assign entry_val = (rd_data_ff[TAG_W+COUNT_W-1:COUNT_W] == epoch_ff)
                      ? rd_data_ff[COUNT_W-1:0] : '0;
   assign pos_dec      = pos_ff - PW'(1);
   assign low_bit      = pos_ff & (~pos_ff + PW'(1));
   assign pos_in_range = (pos_ff <= PW'(VALUE_MAX));
   assign rd_addr      = pos_dec[AW-1:0];
   assign saturate     = (32'(req_tdata[RANK_W-1:0]) > 32'(VALUE_MAX));
   assign rank_sat     = saturate ? PW'(VALUE_MAX) : PW'(req_tdata[RANK_W-1:0]);
   assign req_tready   = (state_ff == S_IDLE);
   assign accept       = req_tvalid && req_tready;

   always_comb begin
      case (state_ff)
         S_QUERY: begin
            add_a = acc_ff;
            add_b = entry_val;
         end
         S_FINISH: begin
            add_a = acc_ff;
            add_b = COUNT_W'(1);
         end
         S_UPDATE: begin
            add_a = entry_val;
            add_b = here_ff;
         end
         S_TOTAL: begin
            add_a = total_ff;
            add_b = here_ff;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      item_in      = item_ff;
      zero_in      = zero_ff;
      sweep_in     = sweep_ff;
      wr_addr_in   = wr_addr_ff;
      epoch_in     = epoch_ff;
      acc_in       = acc_ff;
      here_in      = here_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff;
      out_here_in  = out_here_ff;
      out_total_in = out_total_ff;
      mem_we       = 1'b0;
      mem_wa       = wr_addr_ff;
      wr_data      = {epoch_ff, add_sum};

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rank_in = rank_sat;
               pos_in  = rank_sat - PW'(1);
               pend_in = 1'b0;
               acc_in  = '0;
               here_in = '0;
               item_in = 1'b1;
               zero_in = (req_tdata[RANK_W-1:0] == '0);
               if (req_tdata[RANK_W-1:0] == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_QUERY;
               end
               if (req_tuser) begin
                  total_in = '0;
                  if (epoch_ff == '1) begin
                     epoch_in = TAG_W'(1);
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + TAG_W'(1);
                  end
               end
            end
         end
         S_SWEEP: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            wr_data  = '0;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(VALUE_MAX - 1)) begin
               if (!item_ff) begin
                  state_in = S_IDLE;
               end else if (zero_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_QUERY;
               end
            end
         end
         S_QUERY: begin
            if (pend_ff) begin
               acc_in = add_sum;
            end
            if (pos_ff != '0) begin
               pos_in  = pos_ff - low_bit;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            here_in  = add_sum;
            pos_in   = rank_ff;
            pend_in  = 1'b0;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (pos_in_range) begin
               wr_addr_in = rd_addr;
               pos_in     = pos_ff + low_bit;
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_TOTAL;
               end
            end
         end
         S_TOTAL: begin
            total_in = add_sum;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_here_in  = here_ff;
               out_total_in = total_ff;
               item_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         epoch_ff     <= TAG_W'(1);
         total_ff     <= '0;
         item_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         total_ff     <= total_in;
         item_ff      <= item_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff      <= rank_in;
      pos_ff       <= pos_in;
      zero_ff      <= zero_in;
      wr_addr_ff   <= wr_addr_in;
      acc_ff       <= acc_in;
      here_ff      <= here_in;
      out_here_ff  <= out_here_in;
      out_total_ff <= out_total_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_wa] <= wr_data;
      end
      rd_data_ff <= tree_mem[rd_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_total_ff, out_here_ff};

endmodule
